[rtl/lnfw_pkg.sv]
// Package for the LCD nibble frame writer.
// Holds the shared constants, the controller state type and the command/status structs.
// No dependencies.
package lnfw_pkg;

  localparam logic       CMD_RAW        = 1'b0;
  localparam logic       CMD_PRINT      = 1'b1;

  localparam logic [7:0] RS_DATA        = 8'h40;
  localparam logic [7:0] EN_STROBE      = 8'h80;
  localparam logic [7:0] CURSOR_TOP     = 8'h82;
  localparam logic [7:0] CURSOR_BOT     = 8'hC2;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;
  localparam logic [7:0] NIB_HI_MASK    = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK    = 8'h0f;

  localparam int         NUM_W          = 14;
  localparam logic [NUM_W-1:0] NUM_MAX  = 14'd9999;
  localparam int         RECIP_W        = 16;
  localparam logic [RECIP_W-1:0] RECIP_DIV10 = 16'd52429;
  localparam int         RECIP_SHIFT    = 19;
  localparam int         DIGITS         = 4;

  localparam logic [2:0] PHASE_EN_HI    = 3'd1;
  localparam logic [2:0] PHASE_LO       = 3'd3;
  localparam logic [2:0] PHASE_EN_LO    = 3'd4;
  localparam logic [2:0] PHASE_LAST     = 3'd5;
  localparam logic [2:0] IDX_LAST_RAW   = 3'd0;
  localparam logic [2:0] IDX_LAST_PRINT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  typedef struct packed {
    logic       load;
    logic [2:0] idx;
    logic [2:0] phase;
  } dp_cmd_t;

  typedef struct packed {
    logic print;
    logic conv_busy;
  } dp_stat_t;

endpackage

[rtl/lnfw_if.sv]
// Handshake channels of the LCD nibble frame writer: input item and result item.
// Depends on nothing.
interface lnfw_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        register_select;
  logic [7:0]  byte_value;
  logic        line;
  logic [13:0] number;

  modport source (output valid, command, register_select, byte_value, line, number,
                  input ready);
  modport sink   (input valid, command, register_select, byte_value, line, number,
                  output ready);
endinterface

interface lnfw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       last;

  modport source (output valid, spi_byte, last, input ready);
  modport sink   (input valid, spi_byte, last, output ready);
endinterface

[rtl/lnfw_datapath.sv]
// Datapath: captures an item, splits the number into decimal digits, forms shift bytes.
// Depends on lnfw_pkg.
module lnfw_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     command,
  input  logic                     register_select,
  input  logic [7:0]               byte_value,
  input  logic                     line,
  input  logic [13:0]              number,
  input  lnfw_pkg::dp_cmd_t        cmd,
  output lnfw_pkg::dp_stat_t       stat,
  output logic [7:0]               spi_byte
);
  import lnfw_pkg::*;

  logic                    print_r;
  logic                    rsel_r;
  logic [7:0]              byte_r;
  logic                    line_r;
  logic [NUM_W-1:0]        val_r;
  logic [NUM_W-1:0]        val_nxt;
  logic [3:0]              dig_r [DIGITS];
  logic                    conv_busy_r;
  logic [1:0]              conv_cnt_r;

  logic [NUM_W+RECIP_W-1:0] prod;
  logic [NUM_W-1:0]         quot;
  logic [NUM_W-1:0]         rem;
  logic [7:0]               lcd_byte;
  logic [7:0]               rs_bits;
  logic [3:0]               nib;
  logic                     strobe;

  assign val_nxt = (number > NUM_MAX) ? NUM_MAX : number;
  assign prod    = val_r * RECIP_DIV10;
  assign quot    = NUM_W'(prod >> RECIP_SHIFT);
  assign rem     = val_r - ((quot << 3) + (quot << 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_busy_r <= 1'b0;
      conv_cnt_r  <= 2'd0;
    end else if (cmd.load) begin
      conv_busy_r <= 1'b1;
      conv_cnt_r  <= 2'd0;
    end else if (conv_busy_r) begin
      conv_cnt_r <= conv_cnt_r + 2'd1;
      if (conv_cnt_r == 2'(DIGITS - 1)) begin
        conv_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      print_r <= command;
      rsel_r  <= register_select;
      byte_r  <= byte_value;
      line_r  <= line;
      val_r   <= val_nxt;
    end else if (conv_busy_r) begin
      val_r                       <= quot;
      dig_r[2'd3 - conv_cnt_r]    <= rem[3:0];
    end
  end

  always_comb begin
    lcd_byte = byte_r;
    rs_bits  = rsel_r ? RS_DATA : 8'h00;
    if (print_r == CMD_PRINT) begin
      rs_bits = RS_DATA;
      case (cmd.idx)
        3'd0: begin
          lcd_byte = line_r ? CURSOR_BOT : CURSOR_TOP;
          rs_bits  = 8'h00;
        end
        3'd1:    lcd_byte = ASCII_ZERO | {4'h0, dig_r[0]};
        3'd2:    lcd_byte = ASCII_ZERO | {4'h0, dig_r[1]};
        3'd3:    lcd_byte = ASCII_ZERO | {4'h0, dig_r[2]};
        default: lcd_byte = ASCII_ZERO | {4'h0, dig_r[3]};
      endcase
    end
  end

  assign nib    = (cmd.phase < PHASE_LO) ? 4'((lcd_byte & NIB_HI_MASK) >> 4)
                                         : 4'(lcd_byte & NIB_LO_MASK);
  assign strobe = (cmd.phase == PHASE_EN_HI) || (cmd.phase == PHASE_EN_LO);

  assign spi_byte       = {4'h0, nib} | rs_bits | (strobe ? EN_STROBE : 8'h00);
  assign stat.print     = print_r;
  assign stat.conv_busy = conv_busy_r;

  a_digits_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (print_r && cmd.idx != 3'd0 && !cmd.load) |-> !conv_busy_r)
    else $error("digit read while conversion still running");

endmodule

[rtl/lnfw_ctrl.sv]
// Controller: accepts an item, then walks the LCD bytes and their six shift phases.
// Depends on lnfw_pkg.
module lnfw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last,
  output lnfw_pkg::dp_cmd_t   cmd,
  input  lnfw_pkg::dp_stat_t  stat
);
  import lnfw_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] last_idx;
  logic       in_fire;
  logic       out_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign last_idx  = stat.print ? IDX_LAST_PRINT : IDX_LAST_RAW;
  assign out_last  = (phase_r == PHASE_LAST) && (idx_r == last_idx);

  assign cmd.load  = in_fire;
  assign cmd.idx   = idx_r;
  assign cmd.phase = phase_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SEND;
          idx_nxt   = 3'd0;
          phase_nxt = 3'd0;
        end
      end
      ST_SEND: begin
        if (out_fire) begin
          if (phase_r == PHASE_LAST) begin
            phase_nxt = 3'd0;
            if (out_last) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end else begin
            phase_nxt = phase_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 3'd0;
      phase_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (phase_r <= PHASE_LAST && idx_r <= last_idx))
    else $error("byte sequencer out of range");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid && idx_r == 3'd0 && phase_r == 3'd0))
    else $error("item accepted without starting its run");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last) |=> in_ready)
    else $error("run did not end after its final byte");

endmodule

[rtl/lcd_nibble_frame_writer.sv]
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    command, register_select, byte_value, line, number
// out_ch     out  valid/ready    spi_byte, last
// An item is taken only when the block is idle; its run then follows one byte per cycle while out_ready is high.
// Raw write: 6 shift bytes per item; print: 30 shift bytes per item.
// The byte sequencer emits one shift byte per cycle while the output is not stalled.
// Digit split runs during the cursor bytes and never stalls the output.
// Reset (rst_n, synchronous) returns the block to idle; output stalls hold the sequencer.
// Depends on lnfw_pkg, lnfw_if, lnfw_ctrl and lnfw_datapath.
module lcd_nibble_frame_writer (
  input  logic       clk,
  input  logic       rst_n,
  lnfw_in_if.sink    in_ch,
  lnfw_out_if.source out_ch
);
  import lnfw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lnfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last),
    .cmd       (cmd),
    .stat      (stat)
  );

  lnfw_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .command         (in_ch.command),
    .register_select (in_ch.register_select),
    .byte_value      (in_ch.byte_value),
    .line            (in_ch.line),
    .number          (in_ch.number),
    .cmd             (cmd),
    .stat            (stat),
    .spi_byte        (out_ch.spi_byte)
  );

endmodule

[test/tb_top.sv]
// Testbench for lcd_nibble_frame_writer: directed table, then random raw writes and prints.
// Expected shift bytes come from a local frame predictor, checked byte by byte at the output.
// Depends on lnfw_pkg, lnfw_if and the lcd_nibble_frame_writer RTL.
`timescale 1ns / 1ps

module tb_top;
  import lnfw_pkg::*;

  localparam logic [7:0] RS_INSTR     = 8'h00;
  localparam int         RAND_ITEMS   = 450;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         CYCLE_LIMIT  = 800000;

  typedef struct packed {
    logic        command;
    logic        register_select;
    logic [7:0]  byte_value;
    logic        line;
    logic [13:0] number;
  } lcd_req_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last;
  } spi_beat_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic clk;
  logic rst_n;

  lnfw_in_if  in_ch ();
  lnfw_out_if out_ch ();

  lcd_nibble_frame_writer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  spi_beat_t   spi_frame_q[$];
  lcd_req_t    dir_req[$];
  int          dir_shown[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic [15:0] stall_tick;
  logic [7:0]  stall_pattern;
  stall_mode_t stall_mode;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic void push_lcd_byte(logic [7:0] rs, logic [7:0] value, bit final_byte);
    logic [7:0] nib[2];
    logic [7:0] base;
    nib[0] = (value & NIB_HI_MASK) >> 4;
    nib[1] = value & NIB_LO_MASK;
    for (int h = 0; h < 2; h++) begin
      base = nib[h] | rs;
      spi_frame_q.push_back('{spi_byte: base, last: 1'b0});
      spi_frame_q.push_back('{spi_byte: base | EN_STROBE, last: 1'b0});
      spi_frame_q.push_back('{spi_byte: base, last: final_byte && (h == 1)});
    end
  endfunction

  // shown >= 0 gives the displayed value directly, bypassing saturation
  function automatic void predict_frames(lcd_req_t req, int shown);
    int         value;
    logic [7:0] digit[4];
    if (req.command == CMD_RAW) begin
      push_lcd_byte(req.register_select ? RS_DATA : RS_INSTR, req.byte_value, 1'b1);
    end else begin
      if (shown >= 0) begin
        value = shown;
      end else begin
        value = (req.number > NUM_MAX) ? int'(NUM_MAX) : int'(req.number);
      end
      digit[0] = 8'(value / 1000);
      digit[1] = 8'((value % 1000) / 100);
      digit[2] = 8'((value % 100) / 10);
      digit[3] = 8'(value % 10);
      push_lcd_byte(RS_INSTR, req.line ? CURSOR_BOT : CURSOR_TOP, 1'b0);
      for (int i = 0; i < 4; i++) begin
        push_lcd_byte(RS_DATA, digit[i] + ASCII_ZERO, i == 3);
      end
    end
  endfunction

  task automatic add_row(logic cmd, logic rs, logic [7:0] bv, logic ln, logic [13:0] num,
                         int shown);
    dir_req.push_back('{command: cmd, register_select: rs, byte_value: bv, line: ln,
                        number: num});
    dir_shown.push_back(shown);
  endtask

  function automatic lcd_req_t rand_req();
    lcd_req_t   req;
    int unsigned pick;
    req.command         = ($urandom_range(0, 1) == 0) ? CMD_RAW : CMD_PRINT;
    req.register_select = 1'($urandom_range(0, 1));
    req.byte_value      = 8'($urandom_range(0, 255));
    req.line            = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      req.number = 14'($urandom_range(0, 9999));
    end else if (pick < 17) begin
      req.number = 14'($urandom_range(10000, 16383));
    end else begin
      req.number = 14'($urandom);
    end
    return req;
  endfunction

  task automatic send_item(lcd_req_t req, int shown);
    in_ch.valid           <= 1'b1;
    in_ch.command         <= req.command;
    in_ch.register_select <= req.register_select;
    in_ch.byte_value      <= req.byte_value;
    in_ch.line            <= req.line;
    in_ch.number          <= req.number;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predict_frames(req, shown);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3, 4:    gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_tick    <= '0;
      stall_pattern <= 8'hff;
      stall_mode    <= STALL_NONE;
      out_ch.ready  <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 16'd1;
      if (stall_tick[5:0] == 6'd0) begin
        stall_mode    <= stall_mode_t'($urandom_range(0, 2));
        stall_pattern <= 8'($urandom_range(1, 255));
      end
      case (stall_mode)
        STALL_NONE:   out_ch.ready <= 1'b1;
        STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default:      out_ch.ready <= stall_pattern[stall_tick[2:0]];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    spi_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (spi_frame_q.size() == 0) begin
        report_mismatch("unexpected spi_byte", out_ch.spi_byte, 0);
      end else begin
        want = spi_frame_q.pop_front();
        if (out_ch.spi_byte !== want.spi_byte) begin
          report_mismatch("spi_byte", out_ch.spi_byte, want.spi_byte);
        end
        if (out_ch.last !== want.last) begin
          report_mismatch("last", out_ch.last, want.last);
        end
      end
    end
  end

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.command         <= CMD_RAW;
    in_ch.register_select <= 1'b0;
    in_ch.byte_value      <= 8'h00;
    in_ch.line            <= 1'b0;
    in_ch.number          <= '0;
    rst_n                 <= 1'b0;

    // raw writes: extremes, both rs settings, ignored fields at both extremes
    add_row(CMD_RAW,   1'b0, 8'h00, 1'b0, 14'd0,     -1);
    add_row(CMD_RAW,   1'b1, 8'hff, 1'b1, 14'd16383, -1);
    add_row(CMD_RAW,   1'b0, 8'hff, 1'b1, 14'd16383, -1);
    add_row(CMD_RAW,   1'b1, 8'h00, 1'b0, 14'd0,     -1);
    add_row(CMD_RAW,   1'b0, 8'h28, 1'b0, 14'h2aaa,  -1);
    add_row(CMD_RAW,   1'b1, 8'h41, 1'b1, 14'h1555,  -1);
    add_row(CMD_RAW,   1'b0, 8'h01, 1'b0, 14'd9999,  -1);
    add_row(CMD_RAW,   1'b1, 8'ha5, 1'b1, 14'd10000, -1);
    add_row(CMD_RAW,   1'b1, 8'h5a, 1'b0, 14'd1,     -1);
    // prints: both lines, digit extremes, saturation
    add_row(CMD_PRINT, 1'b0, 8'h00, 1'b0, 14'd0,     0);
    add_row(CMD_PRINT, 1'b1, 8'hff, 1'b1, 14'd9999,  9999);
    add_row(CMD_PRINT, 1'b0, 8'h00, 1'b0, 14'd10000, 9999);
    add_row(CMD_PRINT, 1'b1, 8'hff, 1'b1, 14'd16383, 9999);
    add_row(CMD_PRINT, 1'b0, 8'h00, 1'b1, 14'h2aaa,  9999);
    add_row(CMD_PRINT, 1'b1, 8'h3c, 1'b0, 14'h1555,  5461);
    add_row(CMD_PRINT, 1'b0, 8'h00, 1'b1, 14'd1234,  1234);
    add_row(CMD_PRINT, 1'b1, 8'hff, 1'b0, 14'd9000,  9000);
    add_row(CMD_PRINT, 1'b0, 8'h77, 1'b1, 14'd5,     -1);
    add_row(CMD_PRINT, 1'b0, 8'h00, 1'b0, 14'd10,    -1);
    add_row(CMD_PRINT, 1'b1, 8'h88, 1'b1, 14'd100,   -1);
    add_row(CMD_PRINT, 1'b0, 8'h00, 1'b0, 14'd9998,  -1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_req.size(); i++) begin
      send_item(dir_req[i], dir_shown[i]);
      pace();
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      send_item(rand_req(), -1);
      pace();
    end
    in_ch.valid <= 1'b0;

    while (spi_frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
